FILE: rtl/digital_input_frequency_reporter_core_defines.svh
// ----------------------------------------------------------------------------
// Digital input frequency reporter assertion macros
// Shared macros for the concurrent checks of the reporter core.
// ----------------------------------------------------------------------------
`ifndef DIGITAL_INPUT_FREQUENCY_REPORTER_CORE_DEFINES_SVH
`define DIGITAL_INPUT_FREQUENCY_REPORTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DIFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DIFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/difr_pkg.sv
// ----------------------------------------------------------------------------
// Digital input frequency reporter package
// Widths, constants, command codes and control structs shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package difr_pkg;

  localparam int NUM_INPUTS          = 20;
  localparam int TICKS_PER_WINDOW    = 1000;
  localparam int REPORT_PERIOD_TICKS = 100;
  localparam int THR_PHASES          = 5;

  localparam int IDX_W     = $clog2(NUM_INPUTS);
  localparam int CHAN_W    = 5;
  localparam int PAYLOAD_W = 20;
  localparam int CNT_W     = 10;
  localparam int WIN_W     = 10;
  localparam int TIMER_W   = 7;
  localparam int THR_W     = 3;
  localparam int CMD_W     = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NOW    = 2'd2;

  localparam logic KIND_BITMASK   = 1'b0;
  localparam logic KIND_FREQUENCY = 1'b1;

  typedef struct packed {
    logic             sample;
    logic             report;
    logic             now;
    logic             scan;
    logic [IDX_W-1:0] idx;
    logic             mask_chk;
    logic             flush;
  } difr_cmd_t;

  typedef struct packed {
    logic timer_due;
    logic pend_valid;
    logic out_free;
  } difr_sts_t;

endpackage

FILE: rtl/digital_input_frequency_reporter_core.sv
// ----------------------------------------------------------------------------
// Digital input frequency reporter core
// Counts edges on frequency inputs, reports latched counts and the digital
// bitmask of the remaining inputs as a stream of messages.
//
//   Channel   Direction  Handshake              Beat contents
//   in        sink       in_valid_i/in_ready_o  cmd_i, pin_levels_i
//   out       source     out_valid_o/out_ready_i message_kind_o, channel_o,
//                                                payload_o, last_of_run_o
//   cfg       sink       cfg_we_i               cfg_wdata_i (frequency mask)
//
// A sample tick or an unused command leaves the controller idle. Report-now
// runs the flush state. A report tick runs the mask and flush states, after
// the scan state when counts are due, which walks the 20 latched counts one
// per cycle while the output is free. Reset clears all but the message data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "digital_input_frequency_reporter_core_defines.svh"

module digital_input_frequency_reporter_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [difr_pkg::NUM_INPUTS-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [difr_pkg::CMD_W-1:0]       cmd_i,
  input  logic [difr_pkg::NUM_INPUTS-1:0]  pin_levels_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             message_kind_o,
  output logic [difr_pkg::CHAN_W-1:0]      channel_o,
  output logic [difr_pkg::PAYLOAD_W-1:0]   payload_o,
  output logic                             last_of_run_o
);

  difr_pkg::difr_cmd_t cmd;
  difr_pkg::difr_sts_t sts;

  difr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  difr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pin_levels_i   (pin_levels_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .message_kind_o (message_kind_o),
    .channel_o      (channel_o),
    .payload_o      (payload_o),
    .last_of_run_o  (last_of_run_o)
  );

  `DIFR_ASSERT_NOW(a_idle_no_pending, in_ready_o, !sts.pend_valid, "pending message while idle")
  `DIFR_ASSERT_NEXT(a_report_busy, in_valid_i && in_ready_o && (cmd_i == difr_pkg::CMD_REPORT), !in_ready_o, "report tick did not occupy the core")
  `DIFR_ASSERT_NOW(a_freq_channel, out_valid_o && message_kind_o, channel_o < difr_pkg::CHAN_W'(difr_pkg::NUM_INPUTS), "frequency message channel out of range")
  `DIFR_ASSERT_NOW(a_mask_channel, out_valid_o && !message_kind_o, channel_o == '0, "bitmask message with nonzero channel")

endmodule

FILE: rtl/difr_ctrl.sv
// ----------------------------------------------------------------------------
// Digital input frequency reporter controller
// Sequences sample, report and report-now commands for the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module difr_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [difr_pkg::CMD_W-1:0] cmd_i,
  input  difr_pkg::difr_sts_t        sts_i,
  output difr_pkg::difr_cmd_t        cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_MASK  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]                 state_q, state_d;
  logic [difr_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.idx = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            difr_pkg::CMD_SAMPLE: begin
              cmd_o.sample = 1'b1;
            end
            difr_pkg::CMD_REPORT: begin
              cmd_o.report = 1'b1;
              idx_d        = '0;
              state_d      = sts_i.timer_due ? ST_SCAN : ST_MASK;
            end
            difr_pkg::CMD_NOW: begin
              cmd_o.now = 1'b1;
              state_d   = ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.out_free) begin
          cmd_o.scan = 1'b1;
          if (idx_q == difr_pkg::IDX_W'(difr_pkg::NUM_INPUTS - 1)) begin
            state_d = ST_MASK;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_MASK: begin
        if (sts_i.out_free) begin
          cmd_o.mask_chk = 1'b1;
          state_d        = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

FILE: rtl/difr_datapath.sv
// ----------------------------------------------------------------------------
// Digital input frequency reporter datapath
// Edge counters, window latches, bitmask tracking and the message registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module difr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [difr_pkg::NUM_INPUTS-1:0]     cfg_wdata_i,
  input  logic [difr_pkg::NUM_INPUTS-1:0]     pin_levels_i,
  input  difr_pkg::difr_cmd_t                 cmd_i,
  output difr_pkg::difr_sts_t                 sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                message_kind_o,
  output logic [difr_pkg::CHAN_W-1:0]         channel_o,
  output logic [difr_pkg::PAYLOAD_W-1:0]      payload_o,
  output logic                                last_of_run_o
);

  logic [difr_pkg::NUM_INPUTS-1:0] mask_q;
  logic [difr_pkg::NUM_INPUTS-1:0] prev_q, prev_d;
  logic [difr_pkg::CNT_W-1:0]      edge_q [difr_pkg::NUM_INPUTS];
  logic [difr_pkg::CNT_W-1:0]      edge_d [difr_pkg::NUM_INPUTS];
  logic [difr_pkg::CNT_W-1:0]      latch_q [difr_pkg::NUM_INPUTS];
  logic [difr_pkg::CNT_W-1:0]      latch_d [difr_pkg::NUM_INPUTS];
  logic [difr_pkg::NUM_INPUTS-1:0] zrep_q, zrep_d;
  logic [difr_pkg::WIN_W-1:0]      win_q, win_d;
  logic [difr_pkg::NUM_INPUTS-1:0] cur_q, cur_d;
  logic [difr_pkg::NUM_INPUTS-1:0] sent_q, sent_d;
  logic [difr_pkg::TIMER_W-1:0]    timer_q, timer_d;
  logic [difr_pkg::THR_W-1:0]      thr_q, thr_d;

  logic                            pend_valid_q, pend_valid_d;
  logic                            pend_kind_q, pend_kind_d;
  logic [difr_pkg::CHAN_W-1:0]     pend_chan_q, pend_chan_d;
  logic [difr_pkg::PAYLOAD_W-1:0]  pend_payload_q, pend_payload_d;

  logic                            out_valid_q, out_valid_d;
  logic                            out_load;
  logic                            out_last;
  logic                            out_kind_q;
  logic [difr_pkg::CHAN_W-1:0]     out_chan_q;
  logic [difr_pkg::PAYLOAD_W-1:0]  out_payload_q;
  logic                            out_last_q;

  logic                            gen_valid;
  logic                            gen_kind;
  logic [difr_pkg::CHAN_W-1:0]     gen_chan;
  logic [difr_pkg::PAYLOAD_W-1:0]  gen_payload;
  logic [difr_pkg::CNT_W-1:0]      sel_latch;
  logic [difr_pkg::NUM_INPUTS-1:0] digital_bits;
  logic                            timer_due;
  logic                            out_free;

  assign digital_bits = pin_levels_i & ~mask_q;
  assign timer_due    = (timer_q >= difr_pkg::TIMER_W'(difr_pkg::REPORT_PERIOD_TICKS));
  assign out_free     = !out_valid_q || out_ready_i;
  assign sel_latch    = latch_q[cmd_i.idx];

  // Sample: per-pin edge counts, window latching, bitmask; report-now: bitmask.
  always_comb begin
    logic toggle;
    logic [difr_pkg::CNT_W-1:0] cnt;
    toggle  = 1'b0;
    cnt     = '0;
    prev_d  = prev_q;
    cur_d   = cur_q;
    win_d   = win_q;
    edge_d  = edge_q;
    latch_d = latch_q;
    if (cmd_i.sample) begin
      for (int i = 0; i < difr_pkg::NUM_INPUTS; i++) begin
        toggle = mask_q[i] && (pin_levels_i[i] != prev_q[i]);
        cnt    = edge_q[i];
        if (toggle && (cnt != difr_pkg::COUNT_MAX)) begin
          cnt = cnt + 1'b1;
        end
        if (mask_q[i]) begin
          prev_d[i] = pin_levels_i[i];
        end
        if (win_q == '0) begin
          latch_d[i] = cnt;
          edge_d[i]  = '0;
        end else begin
          edge_d[i]  = cnt;
        end
      end
      cur_d = digital_bits;
      if (win_q == difr_pkg::WIN_W'(difr_pkg::TICKS_PER_WINDOW - 1)) begin
        win_d = '0;
      end else begin
        win_d = win_q + 1'b1;
      end
    end
    if (cmd_i.now) begin
      cur_d = digital_bits;
    end
  end

  // Report tick and report-now message generation.
  always_comb begin
    timer_d     = timer_q;
    thr_d       = thr_q;
    zrep_d      = zrep_q;
    sent_d      = sent_q;
    gen_valid   = 1'b0;
    gen_kind    = difr_pkg::KIND_BITMASK;
    gen_chan    = '0;
    gen_payload = '0;
    if (cmd_i.report) begin
      timer_d = timer_due ? difr_pkg::TIMER_W'(1) : timer_q + 1'b1;
    end
    if (cmd_i.now) begin
      gen_valid   = 1'b1;
      gen_payload = difr_pkg::PAYLOAD_W'(digital_bits);
    end
    if (cmd_i.scan && mask_q[cmd_i.idx]) begin
      gen_kind    = difr_pkg::KIND_FREQUENCY;
      gen_chan    = difr_pkg::CHAN_W'(cmd_i.idx);
      gen_payload = difr_pkg::PAYLOAD_W'(sel_latch);
      if (sel_latch != '0) begin
        gen_valid              = 1'b1;
        zrep_d[cmd_i.idx]      = 1'b0;
      end else if (!zrep_q[cmd_i.idx]) begin
        gen_valid              = 1'b1;
        zrep_d[cmd_i.idx]      = 1'b1;
      end
    end
    if (cmd_i.mask_chk) begin
      if ((thr_q == '0) && (sent_q != cur_q)) begin
        gen_valid   = 1'b1;
        gen_payload = difr_pkg::PAYLOAD_W'(cur_q);
        sent_d      = cur_q;
      end
      if (thr_q == difr_pkg::THR_W'(difr_pkg::THR_PHASES - 1)) begin
        thr_d = '0;
      end else begin
        thr_d = thr_q + 1'b1;
      end
    end
  end

  // A message waits in the pending stage until the next one shows whether it
  // is the last of its run.
  always_comb begin
    pend_valid_d   = pend_valid_q;
    pend_kind_d    = pend_kind_q;
    pend_chan_d    = pend_chan_q;
    pend_payload_d = pend_payload_q;
    out_load       = 1'b0;
    out_last       = 1'b0;
    if (gen_valid) begin
      out_load       = pend_valid_q;
      pend_valid_d   = 1'b1;
      pend_kind_d    = gen_kind;
      pend_chan_d    = gen_chan;
      pend_payload_d = gen_payload;
    end else if (cmd_i.flush) begin
      out_load     = pend_valid_q;
      out_last     = 1'b1;
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q       <= '0;
      prev_q       <= '0;
      zrep_q       <= '0;
      win_q        <= '0;
      cur_q        <= '0;
      sent_q       <= '0;
      timer_q      <= '0;
      thr_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < difr_pkg::NUM_INPUTS; i++) begin
        edge_q[i]  <= '0;
        latch_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      prev_q       <= prev_d;
      zrep_q       <= zrep_d;
      win_q        <= win_d;
      cur_q        <= cur_d;
      sent_q       <= sent_d;
      timer_q      <= timer_d;
      thr_q        <= thr_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      edge_q       <= edge_d;
      latch_q      <= latch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_kind_q    <= pend_kind_d;
    pend_chan_q    <= pend_chan_d;
    pend_payload_q <= pend_payload_d;
    if (out_load) begin
      out_kind_q    <= pend_kind_q;
      out_chan_q    <= pend_chan_q;
      out_payload_q <= pend_payload_q;
      out_last_q    <= out_last;
    end
  end

  assign sts_o.timer_due  = timer_due;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o    = out_valid_q;
  assign message_kind_o = out_kind_q;
  assign channel_o      = out_chan_q;
  assign payload_o      = out_payload_q;
  assign last_of_run_o  = out_last_q;

endmodule
